FILE: hdl/assert_macros.svh
// Assertion macros shared by the hull RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// cond at one edge implies res at the next
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (res)) \
		else $error("assertion failed");

`endif

FILE: hdl/ghull_pkg.sv
// Constants, point record and geometry compares for the convex hull block.
// Depends on nothing; imported by ghull_cell and graham_scan_convex_hull.
package ghull_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = $clog2(MAX_POINTS + 2);
	localparam int DLT_BITS   = COORD_BITS + 1;

	typedef struct packed {
		logic                       valid;
		logic [IDX_BITS-1:0]        idx;
		logic signed [DLT_BITS-1:0] dx;
		logic signed [DLT_BITS-1:0] dy;
	} point_t;

	// a strictly precedes b around the pivot; load index breaks full ties
	function automatic logic goes_before(point_t a, point_t b);
		logic signed [2*DLT_BITS-1:0] l;
		logic signed [2*DLT_BITS-1:0] r;
		logic                         res;
		l = (2*DLT_BITS)'(a.dy) * (2*DLT_BITS)'(b.dx);
		r = (2*DLT_BITS)'(b.dy) * (2*DLT_BITS)'(a.dx);
		if (a.dx == '0) begin
			if (b.dx == '0)
				res = (a.dy < b.dy) || ((a.dy == b.dy) && (a.idx < b.idx));
			else
				res = 1'b0;
		end else if (b.dx == '0) begin
			res = 1'b1;
		end else if (l != r) begin
			res = l < r;
		end else if (a.dx != b.dx) begin
			res = a.dx < b.dx;
		end else begin
			res = a.idx < b.idx;
		end
		return res;
	endfunction

	// s lies left of, or on, the directed line p->q
	function automatic logic turns_left(point_t p, point_t q, point_t s);
		logic signed [DLT_BITS:0]       ux;
		logic signed [DLT_BITS:0]       uy;
		logic signed [DLT_BITS:0]       vx;
		logic signed [DLT_BITS:0]       vy;
		logic signed [2*DLT_BITS+1:0]   a;
		logic signed [2*DLT_BITS+1:0]   b;
		ux = (DLT_BITS+1)'(q.dx) - (DLT_BITS+1)'(p.dx);
		uy = (DLT_BITS+1)'(q.dy) - (DLT_BITS+1)'(p.dy);
		vx = (DLT_BITS+1)'(s.dx) - (DLT_BITS+1)'(p.dx);
		vy = (DLT_BITS+1)'(s.dy) - (DLT_BITS+1)'(p.dy);
		a = (2*DLT_BITS+2)'(ux) * (2*DLT_BITS+2)'(vy);
		b = (2*DLT_BITS+2)'(uy) * (2*DLT_BITS+2)'(vx);
		return a >= b;
	endfunction

endpackage

FILE: hdl/graham_scan_convex_hull.sv
// Graham-scan convex hull: point store, sorter chain, scan stack and result port.
// Depends on ghull_pkg, ghull_cell and assert_macros.svh.
//
// Points load one per cycle. After the beat marked last_point, with three or more
// stored points, a pivot search and a feed pass each read the point store once per
// point, the sorter chain of MAX_POINTS cells then settles, the scan tests each
// sorted point against the stack, pushing or popping, and each hull vertex leaves
// from the stack memory's registered read port; fewer points are sent back by load
// index. No new point is taken until the last vertex beat is accepted.
`include "assert_macros.svh"

module graham_scan_convex_hull
	import ghull_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    coord_x,
	input  logic signed [15:0]    coord_y,
	input  logic                  last_point,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [5:0]            hull_index,
	output logic                  hull_last
);

	typedef enum logic [3:0] {
		S_LOAD, S_PIV, S_FEED, S_SETTLE, S_START, S_TEST, S_POPW,
		S_FIN1, S_FIN2, S_RD, S_OUT, S_SMALL
	} state_t;

	state_t state_q;

	logic [COORD_BITS-1:0] store_x [MAX_POINTS];
	logic [COORD_BITS-1:0] store_y [MAX_POINTS];
	point_t                hull_stack [MAX_POINTS];

	logic [CNT_BITS-1:0]   cnt_q;
	logic [CNT_BITS-1:0]   ctr_q;
	logic [CNT_BITS-1:0]   depth_q;
	logic                  v_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic signed [COORD_BITS-1:0] sx_rd_q;
	logic signed [COORD_BITS-1:0] sy_rd_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic [IDX_BITS-1:0]   pv_q;
	point_t                feed_q;
	point_t                s_q;
	point_t                e_q;
	point_t                stk_rd_q;

	logic                  in_acc;
	logic                  store_ok;
	logic [CNT_BITS-1:0]   cnt_next;
	logic                  left;
	logic                  pop;
	logic                  shift_en;
	logic                  stk_we;
	point_t                stk_wd;
	logic [IDX_BITS-1:0]   stk_ra;
	point_t                front;

	point_t                held  [MAX_POINTS];
	point_t                passv [MAX_POINTS];

	assign in_acc   = in_valid && in_ready;
	assign store_ok = cnt_q < CNT_BITS'(MAX_POINTS);
	assign cnt_next = store_ok ? cnt_q + 1'b1 : cnt_q;
	assign front    = held[0];
	assign left     = turns_left(s_q, e_q, front);
	assign pop      = (depth_q != '0) && !left;
	assign stk_ra   = IDX_BITS'(depth_q - 1'b1);

	always_comb begin
		shift_en = 1'b0;
		stk_we   = 1'b0;
		stk_wd   = s_q;
		unique case (state_q)
			S_START: shift_en = 1'b1;
			S_TEST: begin
				if (ctr_q != cnt_q && !pop) begin
					shift_en = 1'b1;
					stk_we   = depth_q < CNT_BITS'(MAX_POINTS);
				end
			end
			S_FIN1: stk_we = depth_q < CNT_BITS'(MAX_POINTS);
			S_FIN2: begin
				stk_we = depth_q < CNT_BITS'(MAX_POINTS);
				stk_wd = e_q;
			end
			default: ;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < MAX_POINTS; g++) begin : g_cell
			point_t nh;
			point_t ii;
			if (g == MAX_POINTS - 1) begin : g_tail
				assign nh = '0;
			end else begin : g_mid
				assign nh = held[g+1];
			end
			if (g == 0) begin : g_head
				assign ii = feed_q;
			end else begin : g_body
				assign ii = passv[g-1];
			end
			ghull_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.ins_in   (ii),
				.nxt_held (nh),
				.held     (held[g]),
				.pass_out (passv[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (in_acc && store_ok) begin
			store_x[IDX_BITS'(cnt_q)] <= coord_x[COORD_BITS-1:0];
			store_y[IDX_BITS'(cnt_q)] <= coord_y[COORD_BITS-1:0];
		end
		if (state_q == S_PIV || state_q == S_FEED) begin
			sx_rd_q <= store_x[IDX_BITS'(ctr_q)];
			sy_rd_q <= store_y[IDX_BITS'(ctr_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			hull_stack[IDX_BITS'(depth_q)] <= stk_wd;
		if (state_q == S_TEST || state_q == S_RD)
			stk_rd_q <= hull_stack[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ctr_q   <= '0;
			depth_q <= '0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
			feed_q  <= '0;
			pv_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			s_q     <= '0;
			e_q     <= '0;
		end else begin
			feed_q.valid <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_next;
						ctr_q <= '0;
						v_s1  <= 1'b0;
						if (last_point)
							state_q <= (cnt_next < CNT_BITS'(3)) ? S_SMALL : S_PIV;
					end
				end
				S_PIV, S_FEED: begin
					if (ctr_q < cnt_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= IDX_BITS'(ctr_q);
						ctr_q  <= ctr_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1 && state_q == S_PIV) begin
						if (idx_s1 == '0 || sx_rd_q < px_q ||
						    (sx_rd_q == px_q && sy_rd_q < py_q)) begin
							px_q <= sx_rd_q;
							py_q <= sy_rd_q;
							pv_q <= idx_s1;
						end
					end
					if (v_s1 && state_q == S_FEED && idx_s1 != pv_q) begin
						feed_q.valid <= 1'b1;
						feed_q.idx   <= idx_s1;
						feed_q.dx    <= DLT_BITS'(sx_rd_q) - DLT_BITS'(px_q);
						feed_q.dy    <= DLT_BITS'(sy_rd_q) - DLT_BITS'(py_q);
					end
					if (ctr_q == cnt_q && !v_s1) begin
						state_q <= (state_q == S_PIV) ? S_FEED : S_SETTLE;
						ctr_q   <= '0;
					end
				end
				S_SETTLE: begin
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == CNT_BITS'(MAX_POINTS + 1))
						state_q <= S_START;
				end
				S_START: begin
					s_q     <= '{valid: 1'b1, idx: pv_q, dx: '0, dy: '0};
					e_q     <= front;
					ctr_q   <= CNT_BITS'(2);
					depth_q <= '0;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (ctr_q == cnt_q) begin
						state_q <= S_FIN1;
					end else if (pop) begin
						e_q     <= s_q;
						depth_q <= depth_q - 1'b1;
						state_q <= S_POPW;
					end else begin
						if (stk_we)
							depth_q <= depth_q + 1'b1;
						s_q   <= e_q;
						e_q   <= front;
						ctr_q <= ctr_q + 1'b1;
					end
				end
				S_POPW: begin
					s_q     <= stk_rd_q;
					state_q <= S_TEST;
				end
				S_FIN1: begin
					if (stk_we)
						depth_q <= depth_q + 1'b1;
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if (stk_we)
						depth_q <= depth_q + 1'b1;
					state_q <= S_RD;
				end
				S_RD: begin
					depth_q <= depth_q - 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						if (depth_q == '0) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_SMALL: begin
					if (out_ready) begin
						if (ctr_q == cnt_q - 1'b1) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							ctr_q <= ctr_q + 1'b1;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign in_ready   = state_q == S_LOAD;
	assign out_valid  = state_q == S_OUT || state_q == S_SMALL;
	assign hull_index = (state_q == S_SMALL) ? 6'(ctr_q) : 6'(stk_rd_q.idx);
	assign hull_last  = (state_q == S_SMALL) ? (ctr_q == cnt_q - 1'b1) : (depth_q == '0);

	`ASSERT_ALWAYS(a_depth_bound, clk, arst_n, depth_q <= CNT_BITS'(MAX_POINTS))
	`ASSERT_ALWAYS(a_no_overlap, clk, arst_n, !(in_ready && out_valid))
	`ASSERT_NEXT(a_last_done, clk, arst_n, out_valid && out_ready && hull_last, in_ready)

endmodule

FILE: hdl/ghull_cell.sv
// One sorter cell: keeps the point of its stream that sorts first, passes the rest on.
// Depends on ghull_pkg.
module ghull_cell
	import ghull_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  point_t ins_in,
	input  point_t nxt_held,
	output point_t held,
	output point_t pass_out
);

	point_t held_q;
	point_t pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (shift_en) begin
			held_q <= nxt_held;
			pass_q <= '0;
		end else if (ins_in.valid) begin
			if (!held_q.valid) begin
				held_q <= ins_in;
				pass_q <= '0;
			end else if (goes_before(ins_in, held_q)) begin
				held_q <= ins_in;
				pass_q <= held_q;
			end else begin
				pass_q <= ins_in;
			end
		end else begin
			pass_q <= '0;
		end
	end

	assign held     = held_q;
	assign pass_out = pass_q;

endmodule
